// File: hw/rtl/tcmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcmf_pkg;

   localparam int PIXEL_COUNT = 131072;
   localparam int HISTORY_MAX = 16;

   localparam int PIX_W   = 8;
   localparam int INDEX_W = 17;
   localparam int THR_W   = 8;
   localparam int WIN_W   = 5;
   localparam int CSR_W   = 8;
   localparam int ADDR_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int HIST_W  = HISTORY_MAX;

   localparam logic [THR_W-1:0] THR_RESET = '0;
   localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1);

   typedef enum logic [0:0] {
      CSR_DIFF_THRESHOLD = 1'b0,
      CSR_WINDOW_FRAMES  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [HIST_W-1:0] data;
   } hist_wr_type;

   typedef struct packed {
      logic busy;
   } store_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/tcmf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcmf_req_if;
   logic                           valid;
   logic                           ready;
   logic [tcmf_pkg::PIX_W-1:0]     cur_pixel;
   logic [tcmf_pkg::PIX_W-1:0]     prev_pixel;
   logic [tcmf_pkg::INDEX_W-1:0]   pixel_index;

   modport source (output valid, output cur_pixel, output prev_pixel,
                   output pixel_index, input ready);
   modport sink   (input valid, input cur_pixel, input prev_pixel,
                   input pixel_index, output ready);
endinterface

interface tcmf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tcmf_pkg::PIX_W-1:0] out_pixel;
   logic                       changed_now;

   modport source (output valid, output out_pixel, output changed_now, input ready);
   modport sink   (input valid, input out_pixel, input changed_now, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tcmf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcmf_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 1,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/tcmf_hist_store.sv
`timescale 1ns / 1ps
`default_nettype none

module tcmf_hist_store (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rd_en,
   input  wire logic [tcmf_pkg::ADDR_W-1:0]     rd_addr,
   input  wire tcmf_pkg::hist_wr_type           wr,
   output logic      [tcmf_pkg::HIST_W-1:0]     rd_hist,
   output tcmf_pkg::store_status_type           status
);

   localparam logic [tcmf_pkg::ADDR_W-1:0] LAST_ADDR =
      tcmf_pkg::ADDR_W'(tcmf_pkg::PIXEL_COUNT - 1);

   logic                            busy_ff, busy_in;
   logic [tcmf_pkg::ADDR_W-1:0]     clr_ptr_ff, clr_ptr_in;
   logic [tcmf_pkg::ADDR_W-1:0]     rd_addr_ff;
   logic                            fw_valid_ff, fw_valid_in;
   logic [tcmf_pkg::ADDR_W-1:0]     fw_addr_ff;
   logic [tcmf_pkg::HIST_W-1:0]     fw_data_ff;
   logic [tcmf_pkg::HIST_W-1:0]     ram_data;
   tcmf_pkg::hist_wr_type           ram_wr;

   // clear sweep owns the write port until it ends
   always_comb begin
      busy_in    = busy_ff;
      clr_ptr_in = clr_ptr_ff;
      if (busy_ff) begin
         clr_ptr_in = clr_ptr_ff + tcmf_pkg::ADDR_W'(1);
         if (clr_ptr_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end
      end
      if (busy_ff) begin
         ram_wr.en   = 1'b1;
         ram_wr.addr = clr_ptr_ff;
         ram_wr.data = '0;
      end else begin
         ram_wr = wr;
      end
      fw_valid_in = fw_valid_ff | (wr.en & ~busy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_ptr_ff  <= '0;
         fw_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         clr_ptr_ff  <= clr_ptr_in;
         fw_valid_ff <= fw_valid_in;
      end
   end

   // hold the most recent write to cover a read issued in the same cycle
   always_ff @(posedge clock) begin
      if (wr.en && !busy_ff) begin
         fw_addr_ff <= wr.addr;
         fw_data_ff <= wr.data;
      end
      if (rd_en) begin
         rd_addr_ff <= rd_addr;
      end
   end

   tcmf_ram #(
      .DEPTH (tcmf_pkg::PIXEL_COUNT),
      .WIDTH (tcmf_pkg::HIST_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   assign rd_hist     = (fw_valid_ff && fw_addr_ff == rd_addr_ff) ? fw_data_ff : ram_data;
   assign status.busy = busy_ff;

endmodule

`default_nettype wire

// File: hw/rtl/temporal_change_mask_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Temporal change mask filter for an 8-bit depth pixel stream.
// req_chan carries cur_pixel, prev_pixel and pixel_index; rsp_chan returns
// out_pixel and changed_now, one response per request, in request order.
// A pixel is flagged when |cur_pixel - prev_pixel| exceeds diff_threshold; its
// flag history lives in a 131072 x 16 single-port-write, registered-read RAM.
// The pixel passes only if none of the newest window_frames flags is set.
// Pipeline: the RAM read is issued at the request accept edge; the update
// stage then writes back and loads the output register behind rsp_chan.valid.
// Throughput: one request per cycle while rsp_chan.ready is high; the RAM
// does one read and one write per cycle, and a forwarding register covers a
// read of the entry just written.
// Reset: synchronous; after reset the RAM is cleared one entry per cycle and
// req_chan.ready stays low until all 131072 entries are zero. CSR writes
// are taken at any time and should only be issued while the block is idle.
// Stall: when rsp_chan.ready is low the output register holds, the update
// stage holds behind it and req_chan.ready drops once that stage is full.
module temporal_change_mask_filter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tcmf_req_if.sink                           req_chan,
   tcmf_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_write_en,
   input  wire logic [0:0]                    csr_index,
   input  wire logic [tcmf_pkg::CSR_W-1:0]    csr_wdata
);

   logic [tcmf_pkg::THR_W-1:0]    thr_ff;
   logic [tcmf_pkg::WIN_W-1:0]    win_ff;

   logic                          s1_valid_ff, s1_valid_in;
   logic [tcmf_pkg::PIX_W-1:0]    s1_cur_ff;
   logic [tcmf_pkg::PIX_W-1:0]    s1_prev_ff;
   logic                          s1_in_range_ff;
   logic [tcmf_pkg::ADDR_W-1:0]   s1_addr_ff;

   logic                          out_valid_ff, out_valid_in;
   logic [tcmf_pkg::PIX_W-1:0]    out_pixel_ff;
   logic                          changed_ff;

   logic                          req_accept;
   logic                          s1_adv;
   logic                          out_load;
   logic                          in_range;
   logic [tcmf_pkg::ADDR_W-1:0]   req_addr;
   logic [tcmf_pkg::PIX_W-1:0]    diff;
   logic                          flag;
   logic [tcmf_pkg::HIST_W-1:0]   rd_hist;
   logic [tcmf_pkg::HIST_W-1:0]   hist_old;
   logic [tcmf_pkg::HIST_W-1:0]   hist_new;
   logic [tcmf_pkg::HIST_W-1:0]   win_mask;
   logic                          vetoed;
   tcmf_pkg::hist_wr_type         hist_wr;
   tcmf_pkg::store_status_type    store_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= tcmf_pkg::THR_RESET;
         win_ff <= tcmf_pkg::WIN_RESET;
      end else if (csr_write_en) begin
         unique case (tcmf_pkg::csr_index_type'(csr_index))
            tcmf_pkg::CSR_DIFF_THRESHOLD: thr_ff <= csr_wdata[tcmf_pkg::THR_W-1:0];
            tcmf_pkg::CSR_WINDOW_FRAMES:  win_ff <= csr_wdata[tcmf_pkg::WIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_load       = ~out_valid_ff | rsp_chan.ready;
   assign s1_adv         = s1_valid_ff & out_load;
   assign req_chan.ready = ~store_status.busy & (~s1_valid_ff | out_load);
   assign req_accept     = req_chan.valid & req_chan.ready;

   assign in_range = 32'(req_chan.pixel_index) < tcmf_pkg::PIXEL_COUNT;
   assign req_addr = tcmf_pkg::ADDR_W'(req_chan.pixel_index);

   always_comb begin
      diff     = (s1_cur_ff > s1_prev_ff) ? (s1_cur_ff - s1_prev_ff)
                                          : (s1_prev_ff - s1_cur_ff);
      flag     = diff > thr_ff;
      hist_old = s1_in_range_ff ? rd_hist : '0;
      hist_new = tcmf_pkg::HIST_W'({hist_old, flag});
      for (int k = 0; k < tcmf_pkg::HIST_W; k++) begin
         win_mask[k] = (k == 0) || (k < int'(win_ff));
      end
      vetoed = |(hist_new & win_mask);

      hist_wr.en   = s1_adv & s1_in_range_ff;
      hist_wr.addr = s1_addr_ff;
      hist_wr.data = hist_new;

      s1_valid_in  = req_accept | (s1_valid_ff & ~out_load);
      out_valid_in = s1_valid_ff | (out_valid_ff & ~rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_load ? s1_valid_ff : out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cur_ff      <= req_chan.cur_pixel;
         s1_prev_ff     <= req_chan.prev_pixel;
         s1_in_range_ff <= in_range;
         s1_addr_ff     <= req_addr;
      end
      if (s1_adv) begin
         out_pixel_ff <= vetoed ? '0 : s1_cur_ff;
         changed_ff   <= flag;
      end
   end

   tcmf_hist_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .wr      (hist_wr),
      .rd_hist (rd_hist),
      .status  (store_status)
   );

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_pixel   = out_pixel_ff;
   assign rsp_chan.changed_now = changed_ff;

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      store_status.busy |-> !req_chan.ready)
      else $error("request accepted during history clear");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request lost before update stage");

   a_write_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      hist_wr.en |-> (s1_valid_ff && out_load && !store_status.busy))
      else $error("history written without stage advance");

   a_changed_blanks_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.changed_now) |-> (rsp_chan.out_pixel == '0))
      else $error("flagged pixel passed through");

   a_stage_drains: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_load) |=> out_valid_ff)
      else $error("update stage result dropped");

endmodule

`default_nettype wire

// File: verif/temporal_change_mask_filter_tb.sv
`timescale 1ns / 1ps

module temporal_change_mask_filter_tb;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASE_COUNT     = 8;
   localparam int ITEMS_PER_PHASE = 245;
   localparam int POOL_SIZE       = 8;
   localparam int PRINT_LIMIT     = 40;
   localparam int DIRECTED_COUNT  = 26;

   localparam int PIX_W       = tcmf_pkg::PIX_W;
   localparam int INDEX_W     = tcmf_pkg::INDEX_W;
   localparam int CSR_W       = tcmf_pkg::CSR_W;
   localparam int THR_W       = tcmf_pkg::THR_W;
   localparam int WIN_W       = tcmf_pkg::WIN_W;
   localparam int HISTORY_MAX = tcmf_pkg::HISTORY_MAX;
   localparam int PIXEL_COUNT = tcmf_pkg::PIXEL_COUNT;

   localparam tcmf_pkg::csr_index_type REG_THR = tcmf_pkg::CSR_DIFF_THRESHOLD;
   localparam tcmf_pkg::csr_index_type REG_WIN = tcmf_pkg::CSR_WINDOW_FRAMES;

   typedef enum bit {
      ROW_PIXEL,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_pixel;
      logic             changed_now;
   } pixel_result_type;

   typedef struct packed {
      row_kind_type            kind;
      tcmf_pkg::csr_index_type reg_sel;
      logic [CSR_W-1:0]        wdata;
      logic [PIX_W-1:0]        cur;
      logic [PIX_W-1:0]        prev;
      logic [INDEX_W-1:0]      idx;
      bit                      typed;
      pixel_result_type        result;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd0,   8'd0,   17'h00000, 1'b1, '{8'd0,   1'b0}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd255, 8'd0,   17'h1FFFF, 1'b1, '{8'd0,   1'b1}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd0,   8'd255, 17'h1FFFF, 1'b1, '{8'd0,   1'b1}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd200, 8'd200, 17'h1FFFF, 1'b1, '{8'd200, 1'b0}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd170, 8'd85,  17'h15555, 1'b1, '{8'd0,   1'b1}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd85,  8'd85,  17'h0AAAA, 1'b1, '{8'd85,  1'b0}},
      '{ROW_CSR,   REG_THR, 8'hFF, 8'd0,   8'd0,   17'h00000, 1'b0, '{8'd0,   1'b0}},
      '{ROW_CSR,   REG_WIN, 8'h00, 8'd0,   8'd0,   17'h00000, 1'b0, '{8'd0,   1'b0}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd255, 8'd0,   17'h00001, 1'b1, '{8'd255, 1'b0}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd0,   8'd255, 17'h00001, 1'b1, '{8'd0,   1'b0}},
      '{ROW_CSR,   REG_THR, 8'h0A, 8'd0,   8'd0,   17'h00000, 1'b0, '{8'd0,   1'b0}},
      '{ROW_CSR,   REG_WIN, 8'h1F, 8'd0,   8'd0,   17'h00000, 1'b0, '{8'd0,   1'b0}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd20,  8'd9,   17'h00002, 1'b1, '{8'd0,   1'b1}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd20,  8'd10,  17'h00002, 1'b0, '{8'd0,   1'b0}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd9,   8'd20,  17'h00002, 1'b1, '{8'd0,   1'b1}},
      '{ROW_CSR,   REG_WIN, 8'h02, 8'd0,   8'd0,   17'h00000, 1'b0, '{8'd0,   1'b0}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd50,  8'd50,  17'h00002, 1'b0, '{8'd0,   1'b0}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd50,  8'd50,  17'h00002, 1'b0, '{8'd0,   1'b0}},
      '{ROW_CSR,   REG_THR, 8'h00, 8'd0,   8'd0,   17'h00000, 1'b0, '{8'd0,   1'b0}},
      '{ROW_CSR,   REG_WIN, 8'h10, 8'd0,   8'd0,   17'h00000, 1'b0, '{8'd0,   1'b0}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd1,   8'd0,   17'h00003, 1'b1, '{8'd0,   1'b1}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd1,   8'd1,   17'h00003, 1'b0, '{8'd0,   1'b0}},
      '{ROW_CSR,   REG_WIN, 8'h01, 8'd0,   8'd0,   17'h00000, 1'b0, '{8'd0,   1'b0}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd128, 8'd128, 17'h00003, 1'b1, '{8'd128, 1'b0}},
      '{ROW_CSR,   REG_WIN, 8'hF1, 8'd0,   8'd0,   17'h00000, 1'b0, '{8'd0,   1'b0}},
      '{ROW_PIXEL, REG_THR, 8'h00, 8'd64,  8'd63,  17'h00004, 1'b1, '{8'd0,   1'b1}}
   };

   localparam logic [CSR_W-1:0] PHASE_THRESHOLD [PHASE_COUNT] = '{
      8'd0, 8'd255, 8'd15, 8'd40, 8'd8, 8'd100, 8'd3, 8'd128
   };
   localparam logic [CSR_W-1:0] PHASE_WINDOW [PHASE_COUNT] = '{
      8'h01, 8'h10, 8'h1F, 8'h00, 8'h04, 8'hF1, 8'h08, 8'hE2
   };

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [0:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   tcmf_req_if req_if ();
   tcmf_rsp_if rsp_if ();

   temporal_change_mask_filter u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   logic [HISTORY_MAX-1:0] flag_history [int unsigned];
   logic [THR_W-1:0] threshold_cfg = tcmf_pkg::THR_RESET;
   logic [WIN_W-1:0] window_cfg = tcmf_pkg::WIN_RESET;
   pixel_result_type expected_results [$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   logic [INDEX_W-1:0] index_pool [POOL_SIZE];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic pixel_result_type predict_masked_pixel(
      input logic [PIX_W-1:0]   cur,
      input logic [PIX_W-1:0]   prev,
      input logic [INDEX_W-1:0] idx
   );
      logic [PIX_W-1:0] diff;
      logic flag;
      int unsigned win;
      logic [HISTORY_MAX-1:0] hist;
      pixel_result_type res;
      diff = (cur > prev) ? cur - prev : prev - cur;
      flag = (diff > threshold_cfg);
      win = window_cfg;
      if (win == 0) win = 1;
      if (win > HISTORY_MAX) win = HISTORY_MAX;
      hist = '0;
      if (idx < PIXEL_COUNT && flag_history.exists(idx)) hist = flag_history[idx];
      hist = {hist[HISTORY_MAX-2:0], flag};
      if (idx < PIXEL_COUNT) flag_history[idx] = hist;
      res.changed_now = flag;
      res.out_pixel = ((64'(hist) & ((64'd1 << win) - 64'd1)) != 0) ? '0 : cur;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_pixel_result(input logic [PIX_W-1:0] got_pixel, input logic got_changed);
      pixel_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("response with no request pending");
         return;
      end
      want = expected_results.pop_front();
      if (got_pixel !== want.out_pixel)
         report_mismatch($sformatf("out_pixel got %0d expected %0d", got_pixel, want.out_pixel));
      if (got_changed !== want.changed_now)
         report_mismatch($sformatf("changed_now got %0b expected %0b", got_changed,
                                   want.changed_now));
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            check_pixel_result(rsp_if.out_pixel, rsp_if.changed_now);
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_pixel(
      input logic [PIX_W-1:0]   cur,
      input logic [PIX_W-1:0]   prev,
      input logic [INDEX_W-1:0] idx,
      input bit                 typed,
      input pixel_result_type   typed_result
   );
      pixel_result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.cur_pixel   <= cur;
      req_if.prev_pixel  <= prev;
      req_if.pixel_index <= idx;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      res = predict_masked_pixel(cur, prev, idx);
      if (typed) res = typed_result;
      expected_results.push_back(res);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input tcmf_pkg::csr_index_type sel,
                            input logic [CSR_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= sel;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (sel == tcmf_pkg::CSR_DIFF_THRESHOLD) threshold_cfg = value[THR_W-1:0];
      else window_cfg = value[WIN_W-1:0];
      @(posedge clock);
   endtask

   initial begin
      logic [PIX_W-1:0] cur;
      logic [PIX_W-1:0] prev;
      logic [INDEX_W-1:0] idx;
      int c;
      int delta;
      int pick;
      pixel_result_type unused;
      unused = '0;
      reset              <= 1'b1;
      csr_write_en       <= 1'b0;
      csr_index          <= tcmf_pkg::CSR_DIFF_THRESHOLD;
      csr_wdata          <= '0;
      req_if.valid       <= 1'b0;
      req_if.cur_pixel   <= '0;
      req_if.prev_pixel  <= '0;
      req_if.pixel_index <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r]) begin
         if (DIRECTED_ROWS[r].kind == ROW_CSR) begin
            wait_idle();
            write_csr(DIRECTED_ROWS[r].reg_sel, DIRECTED_ROWS[r].wdata);
         end else begin
            send_pixel(DIRECTED_ROWS[r].cur, DIRECTED_ROWS[r].prev, DIRECTED_ROWS[r].idx,
                       DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         write_csr(tcmf_pkg::CSR_DIFF_THRESHOLD, PHASE_THRESHOLD[phase]);
         write_csr(tcmf_pkg::CSR_WINDOW_FRAMES, PHASE_WINDOW[phase]);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 67; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 67; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase
         index_pool[0] = '0;
         index_pool[1] = '1;
         for (int p = 2; p < POOL_SIZE; p++) index_pool[p] = INDEX_W'($urandom);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) idx = index_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (pick < 90) idx = INDEX_W'(PIXEL_COUNT - 1 - $urandom_range(0, 3));
            else idx = INDEX_W'($urandom);

            // hover around the threshold so both sides of the compare get hit
            prev = PIX_W'($urandom);
            case ($urandom_range(0, 3))
               0: delta = threshold_cfg;
               1: delta = threshold_cfg + 1;
               2: delta = $urandom_range(0, 255);
               default: delta = 0;
            endcase
            if ($urandom_range(0, 1)) delta = -delta;
            c = int'(prev) + delta;
            if (c < 0 || c > 255) c = int'(prev) - delta;
            if (c < 0 || c > 255) c = $urandom_range(0, 255);
            cur = PIX_W'(c);
            send_pixel(cur, prev, idx, 1'b0, unused);
         end
      end

      send_idle_pct = 0;
      wait_idle();
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
